### rtl/core/tss_pkg.sv
package tss_pkg;

  // Scheduler request codes
  typedef enum logic [2:0] {
    ACT_CREATE    = 3'd0,
    ACT_YIELD     = 3'd1,
    ACT_TERMINATE = 3'd2,
    ACT_SEM_INIT  = 3'd3,
    ACT_SEM_WAIT  = 3'd4,
    ACT_SEM_SIGNAL = 3'd5
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NO_YIELD = 2'd1,
    STS_DEADLOCK = 2'd2,
    STS_IDLE     = 2'd3
  } status_t;

  // Sequencer states: take request, semaphore entry ready, link entry ready
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SEM  = 2'd1,
    ST_LINK = 2'd2
  } state_t;

  // Stream widths
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 24;

endpackage

### rtl/core/thread_scheduler_semaphores.sv
// Channel  | Dir | Fields (low bit up)
// ---------+-----+-----------------------------------------------------------
// s_axis   | in  | action[2:0] thread_slot[6:3] sem_index[9:7] init_count[24:10]
// m_axis   | out | running_id[3:0] running_valid[4] switched[5] status[7:6]
//          |     | sem_count_now[23:8]
//
// Each request runs in order: the semaphore entry is read from its memory,
// then the link entry it points to (ready head, or waiter head for a signal),
// then the update is written back and the result registered.
// A new request is taken as soon as the sequencer is back in idle, even while
// the previous result waits; the final step holds while the result register
// is still full. After reset slot 0 runs and all queues are empty.
module thread_scheduler_semaphores #(
  parameter int THREADS    = 16,
  parameter int SEMAPHORES = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // action[2:0] thread_slot[6:3] sem_index[9:7] init_count[24:10]
  input  logic [tss_pkg::S_DATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // running_id[3:0] running_valid[4] switched[5] status[7:6] sem_count_now[23:8]
  output logic [tss_pkg::M_DATA_W-1:0] m_tdata
);

  localparam int IDW = $clog2(THREADS);
  localparam int SW  = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
  localparam int SEW = COUNT_BITS + 2 * IDW + 1;
  localparam int unsigned CMAX_U = (32'd1 << (COUNT_BITS - 1)) - 32'd1;
  localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic signed [COUNT_BITS-1:0] count;
    logic [IDW-1:0]               head;
    logic [IDW-1:0]               tail;
    logic                         nonempty;
  } sem_ent_t;

  // sequencer
  tss_pkg::state_t st, st_next;
  logic accept, link_rd_en, commit;

  // latched request
  tss_pkg::action_t act;
  logic [3:0]  slot;
  logic [2:0]  sidx;
  logic [14:0] icnt;

  // ready queue and running thread
  logic [IDW-1:0] ready_head, ready_tail, running_thread;
  logic ready_nonempty, running_flag;
  logic [IDW-1:0] ready_head_next, ready_tail_next, running_thread_next;
  logic ready_nonempty_next, running_flag_next;

  // memories
  logic [IDW-1:0] link_mem [THREADS];
  logic [IDW-1:0] link_q, link_ra, link_wa, link_wd;
  logic link_we;
  logic [SEW-1:0] sem_rd;
  sem_ent_t se, se_next;
  logic sem_we;

  // datapath scratch
  logic sem_ok, slot_ok;
  logic [IDW-1:0] slot_id, pop_t, link_fwd;
  logic signed [COUNT_BITS-1:0] cnt_out;
  tss_pkg::status_t status;
  logic switched;

  assign accept = s_tvalid && s_tready;
  assign se     = sem_ent_t'(sem_rd);
  assign sem_ok = 32'(sidx) < SEMAPHORES;
  assign slot_ok = 32'(slot) < THREADS;
  assign slot_id = IDW'(slot);

  // next state
  always_comb begin
    st_next = st;
    case (st)
      tss_pkg::ST_IDLE: if (accept) st_next = tss_pkg::ST_SEM;
      tss_pkg::ST_SEM:  st_next = tss_pkg::ST_LINK;
      tss_pkg::ST_LINK: if (commit) st_next = tss_pkg::ST_IDLE;
      default:          st_next = tss_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready   = 1'b0;
    link_rd_en = 1'b0;
    commit     = 1'b0;
    case (st)
      tss_pkg::ST_IDLE: s_tready = 1'b1;
      tss_pkg::ST_SEM:  link_rd_en = 1'b1;
      tss_pkg::ST_LINK: commit = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= tss_pkg::ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= tss_pkg::action_t'(s_tdata[2:0]);
      slot <= s_tdata[6:3];
      sidx <= s_tdata[9:7];
      icnt <= s_tdata[24:10];
    end
  end

  // semaphore table, read on accept, written back on commit
  tss_sem_store #(
    .DEPTH (SEMAPHORES),
    .AW    (SW),
    .DW    (SEW)
  ) u_sem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (SW'(s_tdata[9:7])),
    .rd_data (sem_rd),
    .wr_en   (commit && sem_we),
    .wr_addr (SW'(sidx)),
    .wr_data (SEW'(se_next))
  );

  // shared link memory; signal follows the waiter chain, others the ready chain
  assign link_ra = (act == tss_pkg::ACT_SEM_SIGNAL) ? se.head : ready_head;

  always_ff @(posedge clk) begin
    if (commit && link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (link_rd_en) begin
      link_q <= link_mem[link_ra];
    end
  end

  // request execution
  always_comb begin
    ready_head_next     = ready_head;
    ready_tail_next     = ready_tail;
    ready_nonempty_next = ready_nonempty;
    running_thread_next = running_thread;
    running_flag_next   = running_flag;
    se_next  = se;
    sem_we   = 1'b0;
    link_we  = 1'b0;
    link_wa  = ready_tail;
    link_wd  = running_thread;
    link_fwd = link_q;
    pop_t    = ready_head;
    cnt_out  = '0;
    status   = tss_pkg::STS_OK;
    case (act)
      tss_pkg::ACT_CREATE: begin
        if (slot_ok) begin
          if (ready_nonempty) begin
            link_we = 1'b1;
            link_wd = slot_id;
            ready_tail_next = slot_id;
          end else begin
            ready_head_next = slot_id;
            ready_tail_next = slot_id;
            ready_nonempty_next = 1'b1;
          end
        end
      end
      tss_pkg::ACT_YIELD: begin
        if (!ready_nonempty) begin
          status = tss_pkg::STS_NO_YIELD;
        end else begin
          // running thread goes to the tail before the head is taken
          if (running_flag) begin
            link_we = 1'b1;
            ready_tail_next = running_thread;
            if (ready_tail == ready_head) link_fwd = running_thread;
          end
          if (pop_t == ready_tail_next) ready_nonempty_next = 1'b0;
          else ready_head_next = link_fwd;
          running_thread_next = pop_t;
          running_flag_next = 1'b1;
        end
      end
      tss_pkg::ACT_TERMINATE: begin
        if (ready_nonempty) begin
          if (pop_t == ready_tail) ready_nonempty_next = 1'b0;
          else ready_head_next = link_q;
          running_thread_next = pop_t;
          running_flag_next = 1'b1;
        end else begin
          running_flag_next = 1'b0;
          status = tss_pkg::STS_IDLE;
        end
      end
      tss_pkg::ACT_SEM_INIT: begin
        if (sem_ok) begin
          sem_we = 1'b1;
          se_next.count = (32'(icnt) > CMAX_U) ? CNT_MAX : COUNT_BITS'({1'b0, icnt});
          se_next.head = '0;
          se_next.tail = '0;
          se_next.nonempty = 1'b0;
          cnt_out = se_next.count;
        end
      end
      tss_pkg::ACT_SEM_WAIT: begin
        if (sem_ok) begin
          sem_we = 1'b1;
          if (se.count[COUNT_BITS-1] || se.count == '0) begin
            if (!running_flag || !ready_nonempty) begin
              status = tss_pkg::STS_DEADLOCK;
            end else begin
              se_next.count = (se.count == CNT_MIN) ? CNT_MIN : se.count - CNT_ONE;
              // block the running thread on the semaphore
              if (se.nonempty) begin
                link_we = 1'b1;
                link_wa = se.tail;
                if (se.tail == ready_head) link_fwd = running_thread;
              end else begin
                se_next.head = running_thread;
                se_next.nonempty = 1'b1;
              end
              se_next.tail = running_thread;
              // dispatch the ready head
              if (pop_t == ready_tail) ready_nonempty_next = 1'b0;
              else ready_head_next = link_fwd;
              running_thread_next = pop_t;
            end
          end else begin
            se_next.count = se.count - CNT_ONE;
          end
          cnt_out = se_next.count;
        end
      end
      tss_pkg::ACT_SEM_SIGNAL: begin
        if (sem_ok) begin
          sem_we = 1'b1;
          se_next.count = (se.count == CNT_MAX) ? CNT_MAX : se.count + CNT_ONE;
          if (se.nonempty) begin
            // oldest waiter moves to the ready tail
            if (se.head == se.tail) se_next.nonempty = 1'b0;
            else se_next.head = link_q;
            if (ready_nonempty) begin
              link_we = 1'b1;
              link_wd = se.head;
            end else begin
              ready_head_next = se.head;
              ready_nonempty_next = 1'b1;
            end
            ready_tail_next = se.head;
          end
          cnt_out = se_next.count;
        end
      end
      default: ;
    endcase
  end

  assign switched = (running_flag != running_flag_next) ||
                    (running_flag_next && running_thread != running_thread_next);

  // scheduler registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_head     <= '0;
      ready_tail     <= '0;
      ready_nonempty <= 1'b0;
      running_thread <= '0;
      running_flag   <= 1'b1;
    end else if (commit) begin
      ready_head     <= ready_head_next;
      ready_tail     <= ready_tail_next;
      ready_nonempty <= ready_nonempty_next;
      running_thread <= running_thread_next;
      running_flag   <= running_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata[3:0]  <= running_flag_next ? 4'(running_thread_next) : 4'd0;
      m_tdata[4]    <= running_flag_next;
      m_tdata[5]    <= switched;
      m_tdata[7:6]  <= status;
      m_tdata[23:8] <= 16'(cnt_out);
    end
  end

endmodule

### rtl/core/tss_sem_store.sv
// Semaphore table: one synchronous memory, one read and one write port.
// Each entry carries a valid bit so an entry never written reads as zero
// (count 0, empty wait queue).
module tss_sem_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DW-1:0] rd_q;
  logic rd_vld;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // per-entry written marks
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

### rtl/core/tss_checker.sv
module tss_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a result waiting for the sink keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // idle scheduler reports slot zero
  a_idle_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[4] |-> m_tdata[3:0] == 4'd0)
    else $error("idle result with nonzero running id");

  // going idle means nothing runs; refused requests never switch
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      (m_tdata[7:6] != tss_pkg::STS_IDLE || !m_tdata[4]) &&
      ((m_tdata[7:6] != tss_pkg::STS_NO_YIELD && m_tdata[7:6] != tss_pkg::STS_DEADLOCK)
        || !m_tdata[5]))
    else $error("status inconsistent with running state");

  // one request at a time: no new request right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while previous one in progress");

endmodule

bind thread_scheduler_semaphores tss_checker u_tss_checker (.*);
